### design/kpv_pkg.sv
package kpv_pkg;

   localparam int DATA_W = 32;
   localparam int DT_W   = 16;
   localparam int ACC_W  = 52;
   localparam int DIV_W  = 48;

   typedef logic signed [DATA_W-1:0] q16_type;
   typedef logic [DT_W-1:0]          dt_type;

   // register indexes (paddr[2])
   localparam logic CSR_PROCESS_NOISE     = 1'b0;
   localparam logic CSR_MEASUREMENT_NOISE = 1'b1;

   localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = 32'd655;
   localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;
   localparam q16_type           Q16_ONE               = 32'sd65536;

   function automatic q16_type sat32(input logic signed [ACC_W-1:0] v);
      if (v > 52'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -52'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

### design/kpv_ifs.sv
interface kpv_req_if;
   import kpv_pkg::*;
   logic    valid;
   logic    ready;
   dt_type  time_step;
   q16_type accel;
   q16_type measured_pos;
   modport source (output valid, time_step, accel, measured_pos, input ready);
   modport sink (input valid, time_step, accel, measured_pos, output ready);
endinterface

interface kpv_rsp_if;
   import kpv_pkg::*;
   logic    valid;
   logic    ready;
   q16_type est_position;
   q16_type est_velocity;
   modport source (output valid, est_position, est_velocity, input ready);
   modport sink (input valid, est_position, est_velocity, output ready);
endinterface

### design/kalman_pos_vel_filter.sv
// The gains come from two 48-bit restoring divisions, skipped when S <= 0.
// Throughput: one transaction at a time; the next request is taken in the
//   cycle after the response transaction completes. All products share one
//   33x34 multiplier.
// Reset (synchronous, active high): state to zero, covariance to identity,
//   q = 655 and r = 65536.
module kalman_pos_vel_filter (
   input  logic                         clock,
   input  logic                         reset,
   kpv_req_if.sink                      req_ch,
   kpv_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [kpv_pkg::DATA_W-1:0]   pwdata,
   output logic [kpv_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);
   import kpv_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE, S_HDD_M, S_HDD_A, S_P0_M, S_P0_A, S_P1_M, S_P1_A, S_V_M, S_V_A,
      S_T_M, S_T_A, S_C00A_M, S_C00A_A, S_C00B_M, S_C00B_A, S_C10_M, S_C10_A,
      S_GAIN, S_DIV_INIT, S_DIV_RUN, S_DIV_END,
      S_X0_M, S_X0_A, S_X1_M, S_X1_A,
      S_K10_M, S_K10_A, S_K00_M, S_K00_A, S_K11_M, S_K11_A, S_K01_M, S_K01_A,
      S_OUT
   } state_type;

   state_type state_ff;

   // config
   logic [DATA_W-1:0] q_ff, r_ff;

   // filter state
   q16_type pos_ff, vel_ff, c00_ff, c01_ff, c10_ff, c11_ff;

   // per-transaction working registers
   dt_type                   dt_ff;
   q16_type                  a_ff, z_ff, k0_ff, k1_ff;
   logic [14:0]              hdd_ff;
   logic signed [33:0]       t01_ff;
   logic signed [32:0]       e_ff;
   logic signed [66:0]       prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // divider
   logic [DIV_W-1:0]  dvd_ff, quo_ff;
   logic [32:0]       rem_ff, den_ff;
   logic [5:0]        cnt_ff;
   logic              neg_ff, sel_k1_ff;

   // ---------------- CSR port ----------------
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_MEASUREMENT_NOISE) ? r_ff : q_ff;

   // ---------------- shared multiplier operands ----------------
   logic signed [32:0] op_a;
   logic signed [33:0] op_b;
   logic               sub_op;

   always_comb begin
      op_a   = $signed({17'd0, dt_ff});
      op_b   = $signed({18'd0, dt_ff});
      sub_op = 1'b0;
      unique case (state_ff)
         S_P0_M:   op_b = 34'(vel_ff);
         S_P1_M:   begin op_a = $signed({18'd0, hdd_ff}); op_b = 34'(a_ff); end
         S_V_M:    op_b = 34'(a_ff);
         S_T_M:    op_b = 34'(c11_ff);
         S_C00A_M: op_b = 34'(c10_ff);
         S_C00B_M: op_b = t01_ff;
         S_C10_M:  op_b = 34'(c11_ff);
         S_X0_M:   begin op_a = 33'(k0_ff); op_b = 34'(e_ff); end
         S_X1_M:   begin op_a = 33'(k1_ff); op_b = 34'(e_ff); end
         S_K10_M:  begin op_a = 33'(k1_ff); op_b = 34'(c00_ff); end
         S_K00_M:  begin op_a = 33'(k0_ff); op_b = 34'(c00_ff); end
         S_K11_M:  begin op_a = 33'(k1_ff); op_b = 34'(c01_ff); end
         S_K01_M:  begin op_a = 33'(k0_ff); op_b = 34'(c01_ff); end
         S_K10_A, S_K00_A, S_K11_A, S_K01_A: sub_op = 1'b1;
         default: ;
      endcase
   end

   // round to nearest, ties up, then add/subtract into the accumulator
   logic signed [66:0]      prod_rnd;
   logic signed [ACC_W-1:0] rnd_w, sum_w;
   logic [32:0]             hdd_sum;

   assign prod_rnd = prod_ff + 67'sd32768;
   assign rnd_w    = ACC_W'(prod_rnd >>> 16);
   assign sum_w    = sub_op ? (acc_ff - rnd_w) : (acc_ff + rnd_w);
   assign hdd_sum  = prod_ff[32:0] + 33'd65536;

   // ---------------- divider step ----------------
   logic [33:0] rem_sh, rem_diff;
   logic        div_ge;

   assign rem_sh   = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign div_ge   = !rem_diff[33];

   // S = P00 + r, and the gain result after clamping
   logic signed [33:0] s_w;
   q16_type            k_w;
   q16_type            div_src;
   logic signed [32:0] src_ext, src_mag;

   assign s_w     = $signed({{2{c00_ff[31]}}, c00_ff}) + $signed({2'b00, r_ff});
   assign div_src = sel_k1_ff ? c10_ff : c00_ff;
   assign src_ext = 33'(div_src);
   assign src_mag = div_src[31] ? -src_ext : src_ext;

   always_comb begin
      if (neg_ff) begin
         k_w = (quo_ff > 48'd2147483648) ? 32'sh80000000 : -$signed(quo_ff[31:0]);
      end else begin
         k_w = (quo_ff > 48'd2147483647) ? 32'sh7fffffff : $signed(quo_ff[31:0]);
      end
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = (state_ff == S_OUT);
   assign rsp_ch.est_position = pos_ff;
   assign rsp_ch.est_velocity = vel_ff;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (reset) begin
         state_ff <= S_IDLE;
         q_ff     <= PROCESS_NOISE_RST;
         r_ff     <= MEASUREMENT_NOISE_RST;
         pos_ff   <= '0;
         vel_ff   <= '0;
         c00_ff   <= Q16_ONE;
         c01_ff   <= '0;
         c10_ff   <= '0;
         c11_ff   <= Q16_ONE;
      end else begin
         if (psel && penable && pwrite) begin
            unique case (paddr[2])
               CSR_PROCESS_NOISE:     q_ff <= pwdata;
               CSR_MEASUREMENT_NOISE: r_ff <= pwdata;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  dt_ff    <= req_ch.time_step;
                  a_ff     <= req_ch.accel;
                  z_ff     <= req_ch.measured_pos;
                  state_ff <= S_HDD_M;
               end
            end
            S_HDD_M:  state_ff <= S_HDD_A;
            S_HDD_A: begin
               hdd_ff   <= hdd_sum[31:17];
               state_ff <= S_P0_M;
            end
            // predict state
            S_P0_M: begin acc_ff <= ACC_W'(pos_ff); state_ff <= S_P0_A; end
            S_P0_A: begin acc_ff <= sum_w; state_ff <= S_P1_M; end
            S_P1_M: state_ff <= S_P1_A;
            S_P1_A: begin pos_ff <= sat32(sum_w); state_ff <= S_V_M; end
            S_V_M:  begin acc_ff <= ACC_W'(vel_ff); state_ff <= S_V_A; end
            S_V_A:  begin vel_ff <= sat32(sum_w); state_ff <= S_T_M; end
            // predict covariance; t01 kept unsaturated for P00
            S_T_M:  begin acc_ff <= ACC_W'(c01_ff); state_ff <= S_T_A; end
            S_T_A:  begin t01_ff <= sum_w[33:0]; state_ff <= S_C00A_M; end
            S_C00A_M: begin
               acc_ff   <= ACC_W'(c00_ff) + $signed({20'd0, q_ff});
               state_ff <= S_C00A_A;
            end
            S_C00A_A: begin acc_ff <= sum_w; state_ff <= S_C00B_M; end
            S_C00B_M: state_ff <= S_C00B_A;
            S_C00B_A: begin c00_ff <= sat32(sum_w); state_ff <= S_C10_M; end
            S_C10_M:  begin acc_ff <= ACC_W'(c10_ff); state_ff <= S_C10_A; end
            S_C10_A: begin
               c10_ff   <= sat32(sum_w);
               c01_ff   <= sat32(ACC_W'(t01_ff));
               c11_ff   <= sat32(ACC_W'(c11_ff) + $signed({20'd0, q_ff}));
               state_ff <= S_GAIN;
            end
            // gains; S <= 0 keeps the prediction
            S_GAIN: begin
               e_ff <= 33'(z_ff) - 33'(pos_ff);
               if (!s_w[33] && (s_w != '0)) begin
                  den_ff    <= s_w[32:0];
                  sel_k1_ff <= 1'b0;
                  state_ff  <= S_DIV_INIT;
               end else begin
                  k0_ff    <= '0;
                  k1_ff    <= '0;
                  state_ff <= S_X0_M;
               end
            end
            S_DIV_INIT: begin
               // round half away: divide |num| + S/2
               dvd_ff   <= {src_mag[31:0], 16'd0} + {16'd0, den_ff[32:1]};
               neg_ff   <= div_src[31];
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV_RUN;
            end
            S_DIV_RUN: begin
               dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
               quo_ff <= {quo_ff[DIV_W-2:0], div_ge};
               rem_ff <= div_ge ? rem_diff[32:0] : rem_sh[32:0];
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(DIV_W - 1)) begin
                  state_ff <= S_DIV_END;
               end
            end
            S_DIV_END: begin
               if (sel_k1_ff) begin
                  k1_ff    <= k_w;
                  state_ff <= S_X0_M;
               end else begin
                  k0_ff     <= k_w;
                  sel_k1_ff <= 1'b1;
                  state_ff  <= S_DIV_INIT;
               end
            end
            // correct state
            S_X0_M: begin acc_ff <= ACC_W'(pos_ff); state_ff <= S_X0_A; end
            S_X0_A: begin pos_ff <= sat32(sum_w); state_ff <= S_X1_M; end
            S_X1_M: begin acc_ff <= ACC_W'(vel_ff); state_ff <= S_X1_A; end
            S_X1_A: begin vel_ff <= sat32(sum_w); state_ff <= S_K10_M; end
            // correct covariance; P10 before P00 and P11 before P01, they read old P00/P01
            S_K10_M: begin acc_ff <= ACC_W'(c10_ff); state_ff <= S_K10_A; end
            S_K10_A: begin c10_ff <= sat32(sum_w); state_ff <= S_K00_M; end
            S_K00_M: begin acc_ff <= ACC_W'(c00_ff); state_ff <= S_K00_A; end
            S_K00_A: begin c00_ff <= sat32(sum_w); state_ff <= S_K11_M; end
            S_K11_M: begin acc_ff <= ACC_W'(c11_ff); state_ff <= S_K11_A; end
            S_K11_A: begin c11_ff <= sat32(sum_w); state_ff <= S_K01_M; end
            S_K01_M: begin acc_ff <= ACC_W'(c01_ff); state_ff <= S_K01_A; end
            S_K01_A: begin c01_ff <= sat32(sum_w); state_ff <= S_OUT; end
            S_OUT: begin
               if (rsp_ch.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
